@@ hw/rtl/llu_pkg.sv @@
// Shared types, operation codes and constants for the ladder logic instruction unit.
// No dependencies; llu_exec, the top level and llu_checker import this package.
`default_nettype none

package llu_pkg;

  // Default store sizes handed to the top level parameters
  localparam int unsigned NUM_VARS_DEF   = 128;
  localparam int unsigned NUM_TIMERS_DEF = 64;

  // Field widths of one instruction and one result
  localparam int unsigned OP_W     = 4;
  localparam int unsigned VIDX_W   = 7;
  localparam int unsigned TIDX_W   = 6;
  localparam int unsigned MS_W     = 32;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 40;

  localparam logic [TICK_W-1:0] TICK_RESET  = 16'd100;
  localparam logic [MS_W-1:0]   ELAPSED_MAX = 32'hFFFF_FFFF;

  // Instruction codes; 13 to 15 are unused and change nothing
  typedef enum logic [OP_W-1:0] {
    OP_LD      = 4'd0,
    OP_LDN     = 4'd1,
    OP_AND     = 4'd2,
    OP_ANDN    = 4'd3,
    OP_OR      = 4'd4,
    OP_ORN     = 4'd5,
    OP_NOT     = 4'd6,
    OP_TON     = 4'd7,
    OP_OUT     = 4'd8,
    OP_SET     = 4'd9,
    OP_RESET   = 4'd10,
    OP_ENDRUNG = 4'd11,
    OP_HOST_WR = 4'd12
  } op_t;

  // One instruction as held in the input register
  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [VIDX_W-1:0] var_index;
    logic [TIDX_W-1:0] timer_index;
    logic [MS_W-1:0]   preset_ms;
    logic              host_value;
  } item_t;

  // One timer entry as stored in the timer memory
  typedef struct packed {
    logic            prev_input;
    logic [MS_W-1:0] preset;
    logic [MS_W-1:0] elapsed;
  } tmr_entry_t;

  localparam int unsigned TMR_W = $bits(tmr_entry_t);

  // Outcome of one instruction: state updates and the result fields
  typedef struct packed {
    logic            acc;
    logic            loaded;
    logic            var_we;
    logic            var_wd;
    logic            tmr_we;
    tmr_entry_t      tmr_wd;
    logic            res_var;
    logic [MS_W-1:0] res_elapsed;
  } exec_t;

endpackage

`default_nettype wire

@@ hw/rtl/llu_fwd_ram.sv @@
// Single write port memory with registered read and a one-entry write bypass.
// Depends on nothing outside itself; used for the variable and timer stores.
`default_nettype none

module llu_fwd_ram #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 1,
  parameter int unsigned AW    = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [AW-1:0]    raddr_q;
  logic             fwd_valid;
  logic [AW-1:0]    fwd_addr;
  logic [WIDTH-1:0] fwd_data;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; hold the word while the reader stalls
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_q <= mem[raddr];
      raddr_q <= raddr;
    end
  end

  // Remember the last write, which a read on the same edge misses
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_addr <= waddr;
      fwd_data <= wdata;
    end
  end

  assign rdata = (fwd_valid && (fwd_addr == raddr_q)) ? fwd_data : rdata_q;

endmodule

`default_nettype wire

@@ hw/rtl/llu_exec.sv @@
// Executes one instruction: boolean logic on the rung accumulator, the TON
// timer update and the variable writes. Depends on llu_pkg.
`default_nettype none

module llu_exec
  import llu_pkg::*;
#(
  parameter int unsigned NUM_VARS   = NUM_VARS_DEF,
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  item_t             item,
  input  logic              var_rd,
  input  tmr_entry_t        tmr_rd,
  input  logic              acc,
  input  logic              loaded,
  input  logic [TICK_W-1:0] scan_tick,
  output exec_t             ex
);

  logic            var_ok;
  logic            tmr_ok;
  logic            v;
  logic [MS_W:0]   sum;
  logic [MS_W-1:0] run_elapsed;
  logic [MS_W-1:0] new_preset;
  logic [MS_W-1:0] new_elapsed;
  logic            done;

  assign var_ok = 32'(item.var_index) < 32'(NUM_VARS);
  assign tmr_ok = 32'(item.timer_index) < 32'(NUM_TIMERS);
  assign v      = var_ok & var_rd;

  // Timer: saturating add of the tick, restart on a rising input
  assign sum         = {1'b0, tmr_rd.elapsed} + {{(MS_W + 1 - TICK_W){1'b0}}, scan_tick};
  assign run_elapsed = sum[MS_W] ? ELAPSED_MAX : sum[MS_W-1:0];
  assign new_preset  = (item.preset_ms != '0) ? item.preset_ms : tmr_rd.preset;

  always_comb begin
    if (!acc) begin
      new_elapsed = '0;
    end else if (tmr_rd.prev_input) begin
      new_elapsed = run_elapsed;
    end else begin
      new_elapsed = {{(MS_W - TICK_W){1'b0}}, scan_tick};
    end
  end

  assign done = (new_elapsed >= new_preset) && (new_preset != '0);

  // Decode the operation
  always_comb begin
    ex                   = '0;
    ex.acc               = acc;
    ex.loaded            = loaded;
    ex.tmr_wd.prev_input = acc;
    ex.tmr_wd.preset     = new_preset;
    ex.tmr_wd.elapsed    = new_elapsed;
    case (op_t'(item.operation))
      OP_LD: begin
        ex.acc    = v;
        ex.loaded = 1'b1;
      end
      OP_LDN: begin
        ex.acc    = !v;
        ex.loaded = 1'b1;
      end
      OP_AND: begin
        ex.acc    = loaded ? (acc & v) : v;
        ex.loaded = 1'b1;
      end
      OP_ANDN: begin
        ex.acc    = loaded ? (acc & !v) : !v;
        ex.loaded = 1'b1;
      end
      OP_OR: begin
        ex.acc    = loaded ? (acc | v) : v;
        ex.loaded = 1'b1;
      end
      OP_ORN: begin
        ex.acc    = loaded ? (acc | !v) : !v;
        ex.loaded = 1'b1;
      end
      OP_NOT: begin
        ex.acc    = !acc;
        ex.loaded = 1'b1;
      end
      OP_TON: begin
        ex.tmr_we = tmr_ok;
        ex.acc    = tmr_ok & done;
      end
      OP_OUT: begin
        ex.var_we = var_ok;
        ex.var_wd = acc;
      end
      OP_SET: begin
        ex.var_we = var_ok & acc;
        ex.var_wd = 1'b1;
      end
      OP_RESET: begin
        ex.var_we = var_ok & acc;
        ex.var_wd = 1'b0;
      end
      OP_ENDRUNG: begin
        ex.acc    = 1'b0;
        ex.loaded = 1'b0;
      end
      OP_HOST_WR: begin
        ex.var_we = var_ok;
        ex.var_wd = item.host_value;
      end
      default: begin
      end
    endcase

    // Result fields reflect the state after the instruction
    ex.res_var = ex.var_we ? ex.var_wd : v;
    if (!tmr_ok) begin
      ex.res_elapsed = '0;
    end else if (ex.tmr_we) begin
      ex.res_elapsed = new_elapsed;
    end else begin
      ex.res_elapsed = tmr_rd.elapsed;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ladder_logic_instruction_unit.sv @@
// Top level of the ladder logic instruction unit: input and result registers,
// store clearing, rung state. Depends on llu_pkg, llu_fwd_ram and llu_exec.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  s_      | in        | s_tvalid/s_tready  | tuser: operation; tdata: instruction fields
//  m_      | out       | m_tvalid/m_tready  | tdata: accumulator, var_value, elapsed
//  cfg_    | in        | cfg_wr_en          | cfg_wr_data: scan_tick_ms
//
// One instruction per cycle while results are taken; an accepted instruction passes the
// input register and then the result register, which raises m_tvalid; the input register
// stage is set by the registered read of the variable and timer memories.
// After rst, s_tready stays low while both memories are swept to zero over addresses 0 to
// max(NUM_VARS, NUM_TIMERS) - 1; configuration writes are taken throughout.
// A stalled result holds the result register, the input register still fills,
// then s_tready drops until the result is taken.
`default_nettype none

module ladder_logic_instruction_unit
  import llu_pkg::*;
#(
  parameter int unsigned NUM_VARS   = NUM_VARS_DEF,
  parameter int unsigned NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // Instruction stream
  input  logic                s_tvalid,
  output logic                s_tready,
  // [6:0] var_index, [12:7] timer_index, [44:13] preset_ms, [45] host_value
  input  logic [S_DATA_W-1:0] s_tdata,
  // [3:0] operation
  input  logic [OP_W-1:0]     s_tuser,
  // Result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  // [0] accumulator, [1] var_value, [33:2] timer_elapsed_ms
  output logic [M_DATA_W-1:0] m_tdata,
  // Scan period register
  input  logic                cfg_wr_en,
  input  logic [TICK_W-1:0]   cfg_wr_data
);

  localparam int unsigned VA_W  = $clog2(NUM_VARS);
  localparam int unsigned TA_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CLR_N = (NUM_VARS > NUM_TIMERS) ? NUM_VARS : NUM_TIMERS;
  localparam int unsigned CLR_W = $clog2(CLR_N);

  item_t             in_item;
  item_t             s1_item;
  logic              s1_valid;
  logic              s1_adv;
  logic              accept;
  logic              acc;
  logic              loaded;
  logic [TICK_W-1:0] scan_tick;
  logic              clearing;
  logic [CLR_W-1:0]  clr_cnt;
  logic [31:0]       clr_ext;
  logic [31:0]       in_vi_ext;
  logic [31:0]       in_ti_ext;
  logic [31:0]       s1_vi_ext;
  logic [31:0]       s1_ti_ext;
  logic              var_we;
  logic [VA_W-1:0]   var_waddr;
  logic              var_wdata;
  logic              var_rd;
  logic              tmr_we;
  logic [TA_W-1:0]   tmr_waddr;
  logic [TMR_W-1:0]  tmr_wdata;
  logic [TMR_W-1:0]  tmr_rd;
  exec_t             ex;

  // Unpack the incoming transaction
  assign in_item.operation   = s_tuser;
  assign in_item.var_index   = s_tdata[6:0];
  assign in_item.timer_index = s_tdata[12:7];
  assign in_item.preset_ms   = s_tdata[44:13];
  assign in_item.host_value  = s_tdata[45];

  // Handshake: advance when the result register is free or being emptied
  assign s1_adv   = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !clearing && (!s1_valid || s1_adv);
  assign accept   = s_tvalid && s_tready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= in_item;
    end
  end

  // Scan period register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_tick <= TICK_RESET;
    end else if (cfg_wr_en) begin
      scan_tick <= cfg_wr_data;
    end
  end

  // Sweep both memories to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == CLR_W'(CLR_N - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  assign clr_ext   = 32'(clr_cnt);
  assign in_vi_ext = 32'(in_item.var_index);
  assign in_ti_ext = 32'(in_item.timer_index);
  assign s1_vi_ext = 32'(s1_item.var_index);
  assign s1_ti_ext = 32'(s1_item.timer_index);

  // Memory write ports: sweep first, then instruction writes
  always_comb begin
    if (clearing) begin
      var_we    = clr_ext < 32'(NUM_VARS);
      var_waddr = clr_ext[VA_W-1:0];
      var_wdata = 1'b0;
      tmr_we    = clr_ext < 32'(NUM_TIMERS);
      tmr_waddr = clr_ext[TA_W-1:0];
      tmr_wdata = '0;
    end else begin
      var_we    = s1_adv && ex.var_we;
      var_waddr = s1_vi_ext[VA_W-1:0];
      var_wdata = ex.var_wd;
      tmr_we    = s1_adv && ex.tmr_we;
      tmr_waddr = s1_ti_ext[TA_W-1:0];
      tmr_wdata = ex.tmr_wd;
    end
  end

  llu_fwd_ram #(
    .DEPTH (NUM_VARS),
    .WIDTH (1),
    .AW    (VA_W)
  ) u_var_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (var_we),
    .waddr (var_waddr),
    .wdata (var_wdata),
    .re    (accept),
    .raddr (in_vi_ext[VA_W-1:0]),
    .rdata (var_rd)
  );

  llu_fwd_ram #(
    .DEPTH (NUM_TIMERS),
    .WIDTH (TMR_W),
    .AW    (TA_W)
  ) u_tmr_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (tmr_we),
    .waddr (tmr_waddr),
    .wdata (tmr_wdata),
    .re    (accept),
    .raddr (in_ti_ext[TA_W-1:0]),
    .rdata (tmr_rd)
  );

  llu_exec #(
    .NUM_VARS   (NUM_VARS),
    .NUM_TIMERS (NUM_TIMERS)
  ) u_exec (
    .item      (s1_item),
    .var_rd    (var_rd),
    .tmr_rd    (tmr_entry_t'(tmr_rd)),
    .acc       (acc),
    .loaded    (loaded),
    .scan_tick (scan_tick),
    .ex        (ex)
  );

  // Rung accumulator and loaded flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= 1'b0;
      loaded <= 1'b0;
    end else if (s1_adv) begin
      acc    <= ex.acc;
      loaded <= ex.loaded;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      m_tdata <= {{(M_DATA_W - MS_W - 2){1'b0}}, ex.res_elapsed, ex.res_var, ex.acc};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/llu_checker.sv @@
// Port-level checks on the ladder logic instruction unit, bound to the top level.
// Depends on llu_pkg and ladder_logic_instruction_unit.
`default_nettype none

module llu_checker
  import llu_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [OP_W-1:0]     s_tuser,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  // Hold off instructions while the stores are swept after reset
  a_ready_after_rst: assert property (@(posedge clk) rst |=> !s_tready)
    else $error("s_tready high in the cycle after reset");

  // No result straight out of reset
  a_empty_after_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high in the cycle after reset");

  // An accepted transaction reaches the output after the input register when not held back
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) ##1 (!m_tvalid || m_tready) |=> m_tvalid)
    else $error("result missing two cycles after acceptance");

  // End of rung leaves the accumulator cleared
  a_endrung: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == OP_ENDRUNG)) ##1 (!m_tvalid || m_tready)
    |=> !m_tdata[0])
    else $error("accumulator not cleared by end of rung");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed or dropped");

endmodule

bind ladder_logic_instruction_unit llu_checker u_llu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
